// ===== hw/rtl/coalescing_load_wait_table_macros.svh =====
// Assertion macros for the coalescing load wait table.
// Included by files that carry concurrent assertions; no other dependencies.
`ifndef COALESCING_LOAD_WAIT_TABLE_MACROS_SVH
`define COALESCING_LOAD_WAIT_TABLE_MACROS_SVH

`ifndef SYNTH
// Checked property, disabled while reset is asserted (active low)
`define CLWT_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Checked property, also evaluated during reset
`define CLWT_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define CLWT_ASSERT(lbl, clk, rst_n, prop, msg)
`define CLWT_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

// ===== hw/rtl/clwt_pkg.sv =====
// Shared types and constants of the coalescing load wait table.
// No dependencies; used by the response channel interface, the top level and the testbench.
package clwt_pkg;

    // Default table depth
    localparam int ENTRIES_DEF = 16;

    // Operation codes of the func field
    localparam logic [1:0] FN_REQUEST  = 2'd0;
    localparam logic [1:0] FN_COMPLETE = 2'd1;
    localparam logic [1:0] FN_RELEASE  = 2'd2;

    // Saturation value of the waiter count
    localparam logic [7:0] CNT_MAX = 8'hFF;

    // Result status codes
    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_FULL      = 3'd1,
        ST_NOT_FOUND = 3'd2,
        ST_NOT_READY = 3'd3,
        ST_SATURATED = 3'd4
    } t_status;

    // One table entry as kept in the entry memory
    typedef struct packed {
        logic [15:0] type_id;
        logic [31:0] asset_key;
        logic [7:0]  waiters;
        logic        ready;
        logic [31:0] handle;
    } t_entry;

endpackage

// ===== hw/rtl/clwt_req_if.sv =====
// Request channel of the coalescing load wait table: valid/ready plus payload.
// Depends on nothing; the sink side is the table.
interface clwt_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  func;
    logic [15:0] type_id;
    logic [31:0] asset_key;
    logic [31:0] asset_handle;
    logic [3:0]  slot;

    modport source (output valid, func, type_id, asset_key, asset_handle, slot, input ready);
    modport sink   (input valid, func, type_id, asset_key, asset_handle, slot, output ready);
endinterface

// ===== hw/rtl/clwt_rsp_if.sv =====
// Response channel of the coalescing load wait table: valid/ready plus payload.
// Depends on clwt_pkg for the status type.
interface clwt_rsp_if;
    logic                valid;
    logic                ready;
    clwt_pkg::t_status   status;
    logic                hit_existing;
    logic [3:0]          slot_out;
    logic [31:0]         handle_out;
    logic                entry_freed;

    modport source (output valid, status, hit_existing, slot_out, handle_out, entry_freed,
                    input ready);
    modport sink   (input valid, status, hit_existing, slot_out, handle_out, entry_freed,
                    output ready);
endinterface

// ===== hw/rtl/coalescing_load_wait_table.sv =====
// Coalescing load wait table: table of pending loads with waiter counts.
// Depends on clwt_pkg, clwt_req_if, clwt_rsp_if and the assertion macro header.
//
// Usage:
//   i_req carries one operation per transaction: request (look up by type id
//   and key, join or allocate), completion (store handle, mark ready) or
//   release (hand back the handle of a slot and drop one waiter).
//   o_rsp returns exactly one result transaction per accepted operation.
// Sequencing:
//   Request and completion walk the entry memory one entry per cycle, then
//   pass through S_LAST to S_DONE, where the result is registered once the
//   output register is free; the next operation is taken only after the
//   table has returned to S_IDLE. A release reads its slot directly (S_RDREL,
//   then S_DONE). An unused code goes straight from S_IDLE to S_DONE.
//   The single read port of the entry memory is why the scan reads one entry at a time.
// Reset:
//   Synchronous active-low i_rst_n clears all entry valid bits and the
//   control state; the entry memory itself is not cleared.
// Stall:
//   A finished result sits in the output register. A new operation may be
//   accepted while it waits; that operation holds before write-back until
//   the pending result has been taken.
`include "coalescing_load_wait_table_macros.svh"

module coalescing_load_wait_table #(
    parameter int ENTRIES = clwt_pkg::ENTRIES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    clwt_req_if.sink    i_req,
    clwt_rsp_if.source  o_rsp
);
    import clwt_pkg::*;

    localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int SW = (IW > 4) ? IW : 4;
    localparam logic [IW-1:0] IDX_LAST = IW'(ENTRIES - 1);

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_SCAN  = 5'b00010,
        S_LAST  = 5'b00100,
        S_RDREL = 5'b01000,
        S_DONE  = 5'b10000
    } t_state;

    t_state r_state, n_state;

    // Entry memory and its registered read port
    t_entry        r_mem [ENTRIES];
    t_entry        r_rd_data;
    logic          mem_re;
    logic [IW-1:0] mem_raddr;
    logic          mem_we;
    logic [IW-1:0] mem_waddr;
    t_entry        mem_wdata;

    // Valid bits, one flop per entry
    logic [ENTRIES-1:0] r_valid;

    // Latched operation
    logic [1:0]    r_func;
    logic [15:0]   r_type;
    logic [31:0]   r_key;
    logic [31:0]   r_handle;
    logic [IW-1:0] r_rel_idx;
    logic          r_rel_ok;

    // Scan state
    logic [IW-1:0] r_idx;
    logic          r_chk;
    logic [IW-1:0] r_chk_idx;
    logic          r_hit;
    logic [IW-1:0] r_hit_idx;
    t_entry        r_hit_data;
    logic          r_free_found;
    logic [IW-1:0] r_free_idx;

    // Output register
    logic        r_out_valid;
    t_status     r_out_status;
    logic        r_out_hit;
    logic [3:0]  r_out_slot;
    logic [31:0] r_out_hand;
    logic        r_out_freed;

    // Result of the write-back step
    t_status     res_status;
    logic        res_hit;
    logic [3:0]  res_slot;
    logic [31:0] res_hand;
    logic        res_freed;
    logic        upd_we;
    logic        set_valid;
    logic        clr_valid;
    logic [7:0]  rel_cnt;

    logic          req_fire;
    logic          out_free;
    logic          done_fire;
    logic [SW-1:0] slot_ext;
    logic          entry_match;

    assign req_fire    = i_req.valid && i_req.ready;
    assign out_free    = !r_out_valid || o_rsp.ready;
    assign done_fire   = (r_state == S_DONE) && out_free;
    assign slot_ext    = SW'(i_req.slot);
    assign i_req.ready = (r_state == S_IDLE);

    assign entry_match = r_valid[r_chk_idx] && (r_rd_data.type_id == r_type)
                         && (r_rd_data.asset_key == r_key);

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (req_fire) begin
                    if (i_req.func == FN_RELEASE) begin
                        n_state = S_RDREL;
                    end else if (i_req.func == FN_REQUEST || i_req.func == FN_COMPLETE) begin
                        n_state = S_SCAN;
                    end else begin
                        n_state = S_DONE;
                    end
                end
            end
            S_SCAN: begin
                if (r_idx == IDX_LAST) begin
                    n_state = S_LAST;
                end
            end
            S_LAST:  n_state = S_DONE;
            S_RDREL: n_state = S_DONE;
            S_DONE: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Memory read port control
    always_comb begin
        mem_re    = 1'b0;
        mem_raddr = r_idx;
        if (r_state == S_SCAN) begin
            mem_re = 1'b1;
        end else if (r_state == S_RDREL) begin
            mem_re    = 1'b1;
            mem_raddr = r_rel_idx;
        end
    end

    // Result and write-back decision
    always_comb begin
        res_status = ST_NOT_FOUND;
        res_hit    = 1'b0;
        res_slot   = 4'd0;
        res_hand   = 32'd0;
        res_freed  = 1'b0;
        upd_we     = 1'b0;
        set_valid  = 1'b0;
        clr_valid  = 1'b0;
        mem_waddr  = r_hit_idx;
        mem_wdata  = r_hit_data;
        rel_cnt    = (r_rd_data.waiters != 8'd0) ? r_rd_data.waiters - 8'd1 : 8'd0;
        case (r_func)
            FN_REQUEST: begin
                if (r_hit) begin
                    res_hit  = 1'b1;
                    res_slot = 4'(r_hit_idx);
                    if (r_hit_data.waiters == CNT_MAX) begin
                        res_status = ST_SATURATED;
                    end else begin
                        res_status        = ST_OK;
                        upd_we            = 1'b1;
                        mem_wdata.waiters = r_hit_data.waiters + 8'd1;
                    end
                end else if (r_free_found) begin
                    res_status = ST_OK;
                    res_slot   = 4'(r_free_idx);
                    upd_we     = 1'b1;
                    set_valid  = 1'b1;
                    mem_waddr  = r_free_idx;
                    mem_wdata  = '{type_id: r_type, asset_key: r_key, waiters: 8'd0,
                                   ready: 1'b0, handle: 32'd0};
                end else begin
                    res_status = ST_FULL;
                end
            end
            FN_COMPLETE: begin
                if (r_hit) begin
                    res_status       = ST_OK;
                    res_slot         = 4'(r_hit_idx);
                    upd_we           = 1'b1;
                    mem_wdata.handle = r_handle;
                    mem_wdata.ready  = 1'b1;
                    if (r_hit_data.waiters == 8'd0) begin
                        clr_valid = 1'b1;
                        res_freed = 1'b1;
                    end
                end
            end
            FN_RELEASE: begin
                mem_waddr = r_rel_idx;
                mem_wdata = r_rd_data;
                if (r_rel_ok && r_valid[r_rel_idx]) begin
                    res_slot = 4'(r_rel_idx);
                    if (!r_rd_data.ready) begin
                        res_status = ST_NOT_READY;
                    end else begin
                        res_status        = ST_OK;
                        res_hand          = r_rd_data.handle;
                        upd_we            = 1'b1;
                        mem_wdata.waiters = rel_cnt;
                        if (rel_cnt == 8'd0) begin
                            clr_valid = 1'b1;
                            res_freed = 1'b1;
                        end
                    end
                end
            end
            default: ;
        endcase
    end

    assign mem_we = done_fire && upd_we;

    // Entry memory: one write and one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            r_rd_data <= r_mem[mem_raddr];
        end
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_valid      <= '0;
            r_chk        <= 1'b0;
            r_hit        <= 1'b0;
            r_free_found <= 1'b0;
            r_idx        <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state <= n_state;

            // Valid bits change only at write-back
            if (done_fire && set_valid) begin
                r_valid[mem_waddr] <= 1'b1;
            end else if (done_fire && clr_valid) begin
                r_valid[mem_waddr] <= 1'b0;
            end

            // Scan bookkeeping
            if (req_fire) begin
                r_idx        <= '0;
                r_chk        <= 1'b0;
                r_hit        <= 1'b0;
                r_free_found <= 1'b0;
            end else if (r_state == S_SCAN) begin
                r_idx <= r_idx + 1'b1;
                r_chk <= 1'b1;
            end else begin
                r_chk <= 1'b0;
            end

            // Evaluate the entry read in the previous cycle
            if (r_chk) begin
                if (!r_hit && entry_match) begin
                    r_hit <= 1'b1;
                end
                if (!r_free_found && !r_valid[r_chk_idx]) begin
                    r_free_found <= 1'b1;
                end
            end

            // Output register
            if (done_fire) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (req_fire) begin
            r_func    <= i_req.func;
            r_type    <= i_req.type_id;
            r_key     <= i_req.asset_key;
            r_handle  <= i_req.asset_handle;
            r_rel_idx <= slot_ext[IW-1:0];
            r_rel_ok  <= (32'(i_req.slot) < 32'(ENTRIES));
        end
        if (r_state == S_SCAN) begin
            r_chk_idx <= r_idx;
        end
        if (r_chk && !r_hit && entry_match) begin
            r_hit_idx  <= r_chk_idx;
            r_hit_data <= r_rd_data;
        end
        if (r_chk && !r_free_found && !r_valid[r_chk_idx]) begin
            r_free_idx <= r_chk_idx;
        end
        if (done_fire) begin
            r_out_status <= res_status;
            r_out_hit    <= res_hit;
            r_out_slot   <= res_slot;
            r_out_hand   <= res_hand;
            r_out_freed  <= res_freed;
        end
    end

    assign o_rsp.valid        = r_out_valid;
    assign o_rsp.status       = r_out_status;
    assign o_rsp.hit_existing = r_out_hit;
    assign o_rsp.slot_out     = r_out_slot;
    assign o_rsp.handle_out   = r_out_hand;
    assign o_rsp.entry_freed  = r_out_freed;

    // Checks
    `CLWT_ASSERT(a_freed_ok, i_clk, i_rst_n, o_rsp.valid && o_rsp.entry_freed |-> o_rsp.status == ST_OK, "entry freed on a failing operation")
    `CLWT_ASSERT(a_hand_release, i_clk, i_rst_n, o_rsp.valid && o_rsp.handle_out != 32'd0 |-> o_rsp.status == ST_OK && !o_rsp.hit_existing, "handle returned outside a release")
    `CLWT_ASSERT(a_valid_stable, i_clk, i_rst_n, !done_fire |=> r_valid == $past(r_valid), "valid bits changed outside write-back")
    `CLWT_ASSERT(a_rsp_from_done, i_clk, i_rst_n, $rose(o_rsp.valid) |-> $past(r_state) == S_DONE, "result loaded outside write-back")

endmodule

// ===== tb/testbench.sv =====
// Self-checking testbench for the coalescing load wait table.
// Depends on clwt_pkg, clwt_req_if, clwt_rsp_if and the table RTL; reads no files.
`timescale 1ns / 100ps

module testbench;
    import clwt_pkg::*;

    localparam int          TABLE_SIZE  = ENTRIES_DEF;
    localparam logic [1:0]  FN_UNUSED   = 2'd3;
    localparam int          CYCLE_LIMIT = 400000;
    localparam int          HOLD_CYCLES = 150;
    localparam int          POOL_MAX    = 24;

    // Expected response of one operation
    typedef struct {
        t_status     status;
        logic        hit;
        logic [3:0]  slot;
        logic [31:0] handle;
        logic        freed;
    } t_result;

    // One request transaction; pinned rows carry a typed-in response
    typedef struct {
        logic [1:0]  func;
        logic [15:0] type_id;
        logic [31:0] key;
        logic [31:0] handle;
        logic [3:0]  slot;
        bit          pinned;
        t_result     want;
    } t_op;

    logic clk;
    logic rst_n;

    clwt_req_if req_ch ();
    clwt_rsp_if rsp_ch ();

    coalescing_load_wait_table u_dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch)
    );

    // Shadow copy of the pending-load table
    logic        tbl_valid   [TABLE_SIZE];
    logic [15:0] tbl_type    [TABLE_SIZE];
    logic [31:0] tbl_key     [TABLE_SIZE];
    logic [7:0]  tbl_waiters [TABLE_SIZE];
    logic        tbl_ready   [TABLE_SIZE];
    logic [31:0] tbl_handle  [TABLE_SIZE];

    t_result     pending_results [$];
    t_op         cur_op;
    t_op         directed_ops [$];
    logic [15:0] pool_type [POOL_MAX];
    logic [31:0] pool_key  [POOL_MAX];

    int errors;
    int ops_accepted;
    int results_seen;
    int status_seen [8];
    int cycles;
    int burst_left;
    int hold_asked;
    int hold_done;
    int hold_left;
    int rx_mode;
    int rx_left;

    // Clock
    initial begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Run limit
    initial begin
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge clk);
            cycles++;
        end
        $display("timeout after %0d cycles", cycles);
        $display("testbench NOT OK");
        $finish;
    end

    // Predict one operation and update the shadow table
    function automatic t_result table_step(t_op op);
        t_result res;
        int      hit_idx;
        int      free_idx;
        res      = '{ST_NOT_FOUND, 1'b0, 4'd0, 32'd0, 1'b0};
        hit_idx  = -1;
        free_idx = -1;
        // lowest matching and lowest free slot
        for (int i = TABLE_SIZE - 1; i >= 0; i--) begin
            if (tbl_valid[i] && tbl_type[i] == op.type_id && tbl_key[i] == op.key)
                hit_idx = i;
            if (!tbl_valid[i])
                free_idx = i;
        end
        case (op.func)
            FN_REQUEST: begin
                if (hit_idx >= 0) begin
                    res.hit  = 1'b1;
                    res.slot = 4'(hit_idx);
                    if (tbl_waiters[hit_idx] == CNT_MAX) begin
                        res.status = ST_SATURATED;
                    end else begin
                        tbl_waiters[hit_idx]++;
                        res.status = ST_OK;
                    end
                end else if (free_idx < 0) begin
                    res.status = ST_FULL;
                end else begin
                    tbl_valid[free_idx]   = 1'b1;
                    tbl_type[free_idx]    = op.type_id;
                    tbl_key[free_idx]     = op.key;
                    tbl_waiters[free_idx] = 8'd0;
                    tbl_ready[free_idx]   = 1'b0;
                    tbl_handle[free_idx]  = 32'd0;
                    res.slot   = 4'(free_idx);
                    res.status = ST_OK;
                end
            end
            FN_COMPLETE: begin
                if (hit_idx >= 0) begin
                    tbl_handle[hit_idx] = op.handle;
                    tbl_ready[hit_idx]  = 1'b1;
                    res.slot   = 4'(hit_idx);
                    res.status = ST_OK;
                    if (tbl_waiters[hit_idx] == 8'd0) begin
                        tbl_valid[hit_idx] = 1'b0;
                        res.freed = 1'b1;
                    end
                end
            end
            FN_RELEASE: begin
                if (tbl_valid[op.slot]) begin
                    res.slot = op.slot;
                    if (!tbl_ready[op.slot]) begin
                        res.status = ST_NOT_READY;
                    end else begin
                        res.status = ST_OK;
                        res.handle = tbl_handle[op.slot];
                        if (tbl_waiters[op.slot] > 8'd0)
                            tbl_waiters[op.slot]--;
                        if (tbl_waiters[op.slot] == 8'd0) begin
                            tbl_valid[op.slot] = 1'b0;
                            res.freed = 1'b1;
                        end
                    end
                end
            end
            default: ;
        endcase
        return res;
    endfunction

    function automatic t_op make_op(logic [1:0] f, logic [15:0] t, logic [31:0] k,
                                    logic [31:0] h, logic [3:0] s);
        t_op op;
        op.func    = f;
        op.type_id = t;
        op.key     = k;
        op.handle  = h;
        op.slot    = s;
        op.pinned  = 1'b0;
        op.want    = '{ST_OK, 1'b0, 4'd0, 32'd0, 1'b0};
        return op;
    endfunction

    function automatic t_op pin(t_op op, t_status st, logic hit, logic [3:0] sl,
                                logic [31:0] hd, logic fr);
        t_op res;
        res        = op;
        res.pinned = 1'b1;
        res.want   = '{st, hit, sl, hd, fr};
        return res;
    endfunction

    // Random operation: mostly well-formed traffic on a small pool of loads
    function automatic t_op random_op(int pool_n, int req_weight);
        t_op op;
        int  r;
        int  p;
        int  cand [$];
        r  = $urandom_range(0, 99);
        p  = $urandom_range(0, pool_n - 1);
        op = make_op(FN_REQUEST, pool_type[p], pool_key[p], $urandom, 4'($urandom));
        if (r < 4) begin
            op.func    = 2'($urandom_range(0, 3));
            op.type_id = 16'($urandom);
            op.key     = $urandom;
        end else if (r < 4 + req_weight) begin
            op.func = FN_REQUEST;
        end else if (r < 29 + req_weight) begin
            op.func = FN_COMPLETE;
        end else begin
            op.func = FN_RELEASE;
            for (int i = 0; i < TABLE_SIZE; i++)
                if (tbl_valid[i]) cand.push_back(i);
            if (cand.size() > 0 && $urandom_range(0, 4) != 0)
                op.slot = 4'(cand[$urandom_range(0, cand.size() - 1)]);
        end
        return op;
    endfunction

    task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want) begin
            errors++;
            $display("%0t: %s mismatch: expected %0h, got %0h", $time, name, want, got);
        end
    endtask

    // Scoreboard: predict on accepted operations, compare accepted responses
    always @(posedge clk) begin
        t_result want;
        if (rst_n) begin
            if (req_ch.valid === 1'b1 && req_ch.ready === 1'b1) begin
                want = table_step(cur_op);
                if (cur_op.pinned)
                    want = cur_op.want;
                pending_results.push_back(want);
                ops_accepted++;
            end
            if (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
                results_seen++;
                if (!$isunknown(rsp_ch.status))
                    status_seen[rsp_ch.status]++;
                if (pending_results.size() == 0) begin
                    errors++;
                    $display("%0t: response with nothing expected: status %0d slot %0d",
                             $time, rsp_ch.status, rsp_ch.slot_out);
                end else begin
                    want = pending_results.pop_front();
                    check_field("status", 32'(want.status), 32'(rsp_ch.status));
                    check_field("hit_existing", 32'(want.hit), 32'(rsp_ch.hit_existing));
                    check_field("slot_out", 32'(want.slot), 32'(rsp_ch.slot_out));
                    check_field("handle_out", want.handle, rsp_ch.handle_out);
                    check_field("entry_freed", 32'(want.freed), 32'(rsp_ch.entry_freed));
                end
            end
        end
    end

    // Response side: stall patterns of its own, plus long hold-offs on request
    always @(negedge clk) begin
        if (hold_asked != hold_done) begin
            hold_done++;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            rsp_ch.ready <= 1'b0;
        end else begin
            if (rx_left == 0) begin
                rx_mode = $urandom_range(0, 3);
                rx_left = $urandom_range(20, 80);
            end
            rx_left--;
            case (rx_mode)
                0:       rsp_ch.ready <= 1'b1;
                1:       rsp_ch.ready <= 1'($urandom_range(0, 1));
                2:       rsp_ch.ready <= ($urandom_range(0, 3) == 0);
                default: rsp_ch.ready <= ((rx_left % 8) < 3);
            endcase
        end
    end

    // Drive one transaction and wait for it to be taken
    task automatic send_op(input t_op op);
        @(negedge clk);
        req_ch.valid        <= 1'b1;
        req_ch.func         <= op.func;
        req_ch.type_id      <= op.type_id;
        req_ch.asset_key    <= op.key;
        req_ch.asset_handle <= op.handle;
        req_ch.slot         <= op.slot;
        cur_op              <= op;
        do @(posedge clk); while (req_ch.ready !== 1'b1);
    endtask

    task automatic pause_sender(input int n);
        @(negedge clk);
        req_ch.valid <= 1'b0;
        repeat (n - 1) @(negedge clk);
    endtask

    // Send in bursts of random length with random gaps
    task automatic offer(input t_op op);
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 10);
            if ($urandom_range(0, 3) != 0)
                pause_sender($urandom_range(1, 8));
        end
        burst_left--;
        send_op(op);
    endtask

    task automatic wait_results_done();
        pause_sender(1);
        while (pending_results.size() != 0) @(posedge clk);
    endtask

    // Complete every pending load; entries nobody waits on are freed, the
    // rest stay ready so that later releases hand back their handles
    task automatic flush_table();
        for (int s = 0; s < TABLE_SIZE; s++) begin
            if (tbl_valid[s] && !tbl_ready[s])
                send_op(make_op(FN_COMPLETE, tbl_type[s], tbl_key[s], $urandom, 4'd0));
        end
        wait_results_done();
    endtask

    task automatic run_random(input int n_ops, input int pool_n, input int req_weight,
                              input int hold_at);
        for (int i = 0; i < pool_n; i++) begin
            pool_type[i] = (i % 4 == 1) ? pool_type[i - 1] : 16'($urandom);
            pool_key[i]  = (i % 4 == 2) ? pool_key[i - 1] : $urandom;
        end
        for (int i = 0; i < n_ops; i++) begin
            if (i == hold_at)
                hold_asked++;
            offer(random_op(pool_n, req_weight));
        end
        wait_results_done();
    endtask

    // Main sequence
    initial begin
        rst_n               = 1'b0;
        req_ch.valid        = 1'b0;
        req_ch.func         = FN_REQUEST;
        req_ch.type_id      = 16'd0;
        req_ch.asset_key    = 32'd0;
        req_ch.asset_handle = 32'd0;
        req_ch.slot         = 4'd0;
        rsp_ch.ready        = 1'b0;
        errors = 0; ops_accepted = 0; results_seen = 0;
        burst_left = 0; hold_asked = 0; hold_done = 0; hold_left = 0;
        rx_mode = 0; rx_left = 0;
        foreach (status_seen[i]) status_seen[i] = 0;
        foreach (tbl_valid[i]) begin
            tbl_valid[i] = 1'b0; tbl_type[i] = '0; tbl_key[i] = '0;
            tbl_waiters[i] = '0; tbl_ready[i] = 1'b0; tbl_handle[i] = '0;
        end
        cur_op = make_op(FN_REQUEST, 16'd0, 32'd0, 32'd0, 4'd0);

        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed rows: empty table, extremes, coalescing, ready handling
        directed_ops.push_back(pin(make_op(FN_RELEASE, 16'h0, 32'h0, 32'h0, 4'd0),
                               ST_NOT_FOUND, 1'b0, 4'd0, 32'd0, 1'b0));
        directed_ops.push_back(pin(make_op(FN_RELEASE, 16'hFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF,
                               4'd15), ST_NOT_FOUND, 1'b0, 4'd0, 32'd0, 1'b0));
        directed_ops.push_back(pin(make_op(FN_COMPLETE, 16'hFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF,
                               4'd15), ST_NOT_FOUND, 1'b0, 4'd0, 32'd0, 1'b0));
        directed_ops.push_back(pin(make_op(FN_UNUSED, 16'hFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF,
                               4'd15), ST_NOT_FOUND, 1'b0, 4'd0, 32'd0, 1'b0));
        directed_ops.push_back(pin(make_op(FN_REQUEST, 16'h0, 32'h0, 32'hFFFFFFFF, 4'd15),
                               ST_OK, 1'b0, 4'd0, 32'd0, 1'b0));
        directed_ops.push_back(pin(make_op(FN_REQUEST, 16'hFFFF, 32'hFFFFFFFF, 32'h0, 4'd0),
                               ST_OK, 1'b0, 4'd1, 32'd0, 1'b0));
        directed_ops.push_back(pin(make_op(FN_REQUEST, 16'h0, 32'h0, 32'h0, 4'd0),
                               ST_OK, 1'b1, 4'd0, 32'd0, 1'b0));
        // same type, different key, and the reverse
        directed_ops.push_back(pin(make_op(FN_REQUEST, 16'h0, 32'hFFFFFFFF, 32'h0, 4'd0),
                               ST_OK, 1'b0, 4'd2, 32'd0, 1'b0));
        directed_ops.push_back(pin(make_op(FN_REQUEST, 16'hFFFF, 32'h0, 32'h0, 4'd0),
                               ST_OK, 1'b0, 4'd3, 32'd0, 1'b0));
        directed_ops.push_back(pin(make_op(FN_RELEASE, 16'h0, 32'h0, 32'h0, 4'd0),
                               ST_NOT_READY, 1'b0, 4'd0, 32'd0, 1'b0));
        directed_ops.push_back(pin(make_op(FN_COMPLETE, 16'h0, 32'h0, 32'hFFFFFFFF, 4'd0),
                               ST_OK, 1'b0, 4'd0, 32'd0, 1'b0));
        // second completion overwrites the handle
        directed_ops.push_back(pin(make_op(FN_COMPLETE, 16'h0, 32'h0, 32'h5A5AA5A5, 4'd0),
                               ST_OK, 1'b0, 4'd0, 32'd0, 1'b0));
        directed_ops.push_back(pin(make_op(FN_RELEASE, 16'h0, 32'h0, 32'h0, 4'd0),
                               ST_OK, 1'b0, 4'd0, 32'h5A5AA5A5, 1'b1));
        // completion with nobody waiting frees at once
        directed_ops.push_back(pin(make_op(FN_COMPLETE, 16'hFFFF, 32'hFFFFFFFF, 32'h0, 4'd0),
                               ST_OK, 1'b0, 4'd1, 32'd0, 1'b1));
        directed_ops.push_back(pin(make_op(FN_RELEASE, 16'h0, 32'h0, 32'h0, 4'd1),
                               ST_NOT_FOUND, 1'b0, 4'd0, 32'd0, 1'b0));
        directed_ops.push_back(pin(make_op(FN_REQUEST, 16'h1234, 32'h89ABCDEF, 32'h0, 4'd0),
                               ST_OK, 1'b0, 4'd0, 32'd0, 1'b0));
        // fill the table with fresh loads; the last one finds it full
        repeat (14)
            directed_ops.push_back(make_op(FN_REQUEST, 16'($urandom), $urandom, $urandom,
                                   4'($urandom)));
        foreach (directed_ops[i])
            offer(directed_ops[i]);

        // Waiter count up to saturation, back to back
        repeat (255)
            send_op(make_op(FN_REQUEST, 16'h1234, 32'h89ABCDEF, $urandom, 4'($urandom)));
        send_op(pin(make_op(FN_REQUEST, 16'h1234, 32'h89ABCDEF, 32'h0, 4'd0),
                ST_SATURATED, 1'b1, 4'd0, 32'd0, 1'b0));
        wait_results_done();
        flush_table();

        // Random traffic: request-heavy with a large pool, then balanced
        run_random(70, 20, 55, 40);
        flush_table();
        run_random(70, 10, 35, 0);

        wait_results_done();
        repeat (40) @(posedge clk);

        $display("ran %0d operations in %0d cycles, %0d responses checked, %0d hold-offs",
                 ops_accepted, cycles, results_seen, hold_done);
        $display("responses by status: ok %0d full %0d not-found %0d not-ready %0d sat %0d",
                 status_seen[ST_OK], status_seen[ST_FULL], status_seen[ST_NOT_FOUND],
                 status_seen[ST_NOT_READY], status_seen[ST_SATURATED]);
        if (errors == 0 && pending_results.size() == 0) begin
            $display("testbench OK");
        end else begin
            $display("%0d errors, %0d responses missing", errors, pending_results.size());
            $display("testbench NOT OK");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+hw/rtl
hw/rtl/clwt_pkg.sv
hw/rtl/clwt_req_if.sv
hw/rtl/clwt_rsp_if.sv
hw/rtl/coalescing_load_wait_table.sv
tb/testbench.sv
